>>> rtl/pbwf_pkg.sv
// Shared types and constants of the peak-bounded window finder.
package pbwf_pkg;

  localparam int DEF_MAX_SAMPLES = 4096;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int JOB_CNT_W = 17;
  localparam int JOB_SMP_W = 32;

  localparam int START_W = 12;
  localparam int END_W   = 12;
  localparam int LEN_W   = 13;
  localparam int MIN_GAP = 10;

  typedef struct packed {
    logic                        bank;
    logic                        dropped;
    logic [JOB_CNT_W-1:0]        count;
    logic signed [JOB_SMP_W-1:0] peak;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FWD,
    ST_BWD,
    ST_SUM,
    ST_PREP,
    ST_DIV,
    ST_OUT
  } back_st_t;

endpackage

>>> rtl/peak_bounded_window_finder_top.sv
// Sample blocks are loaded at one transaction per cycle into one of two memory banks.
// Each block is analyzed (forward scan, backward scan, window sum, one-bit-per-cycle
// divider) while the next block loads; loading stalls only when the queue holds two
// finished blocks, the one under analysis and one waiting.
// Synchronous active-low reset clears all control state; memory contents are not cleared.
module peak_bounded_window_finder_top #(
  parameter int MAX_SAMPLES = pbwf_pkg::DEF_MAX_SAMPLES,
  parameter int SAMPLE_BITS = pbwf_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // Fields from bit 0: sample.
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       in_tdata,
  input  logic                                   in_tlast,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // Fields from bit 0: window_start, window_end, window_length, peak_value,
  // window_mean, overflow.
  output logic [((38+2*SAMPLE_BITS+7)/8)*8-1:0]  out_tdata
);
  import pbwf_pkg::*;

  logic                         q_full, q_empty, q_push, q_pop;
  job_t                         push_job, head_job;
  logic                         wr_en;
  logic [$clog2(MAX_SAMPLES):0] wr_addr;
  logic [SAMPLE_BITS-1:0]       wr_data;

  pbwf_front #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tlast (in_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  pbwf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_job(push_job),
    .pop     (q_pop),
    .head_job(head_job),
    .full    (q_full),
    .empty   (q_empty)
  );

  pbwf_back #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .q_empty   (q_empty),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule

>>> rtl/pbwf_front.sv
// Input side: stores samples into the free bank and tracks count, peak and drops.
module pbwf_front #(
  parameter int MAX_SAMPLES = pbwf_pkg::DEF_MAX_SAMPLES,
  parameter int SAMPLE_BITS = pbwf_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       in_tdata,
  input  logic                                   in_tlast,
  input  logic                                   q_full,
  output logic                                   q_push,
  output pbwf_pkg::job_t                         q_job,
  output logic                                   wr_en,
  output logic [$clog2(MAX_SAMPLES):0]           wr_addr,
  output logic [SAMPLE_BITS-1:0]                 wr_data
);
  import pbwf_pkg::*;

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  logic [CW-1:0]                 fill_r, fill_nxt;
  logic signed [SAMPLE_BITS-1:0] max_r, max_nxt;
  logic                          drop_r, drop_nxt;
  logic                          bank_r, bank_nxt;
  logic signed [SAMPLE_BITS-1:0] x;
  logic                          acc;
  logic                          store;

  assign x         = in_tdata[SAMPLE_BITS-1:0];
  assign in_tready = !q_full;
  assign acc       = in_tvalid && !q_full;
  assign store     = fill_r < CW'(MAX_SAMPLES);
  assign wr_en     = acc && store;
  assign wr_addr   = {bank_r, fill_r[AW-1:0]};
  assign wr_data   = x;

  always_comb begin
    fill_nxt = fill_r;
    max_nxt  = max_r;
    drop_nxt = drop_r;
    bank_nxt = bank_r;
    q_push   = 1'b0;
    q_job    = '0;
    if (acc) begin
      if (store) begin
        fill_nxt = fill_r + CW'(1);
        if (fill_r == '0 || x > max_r) begin
          max_nxt = x;
        end
      end else begin
        drop_nxt = 1'b1;
      end
      if (in_tlast) begin
        q_push        = 1'b1;
        q_job.bank    = bank_r;
        q_job.dropped = drop_nxt;
        q_job.count   = JOB_CNT_W'(fill_nxt);
        q_job.peak    = JOB_SMP_W'(max_nxt);
        fill_nxt      = '0;
        max_nxt       = '0;
        drop_nxt      = 1'b0;
        bank_nxt      = !bank_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      max_r  <= '0;
      drop_r <= 1'b0;
      bank_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      max_r  <= max_nxt;
      drop_r <= drop_nxt;
      bank_r <= bank_nxt;
    end
  end

endmodule

>>> rtl/pbwf_queue.sv
// Two-entry queue of finished blocks waiting for the analysis side.
module pbwf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pbwf_pkg::job_t push_job,
  input  logic           pop,
  output pbwf_pkg::job_t head_job,
  output logic           full,
  output logic           empty
);
  import pbwf_pkg::*;

  job_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;
  assign head_job = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

>>> rtl/pbwf_back.sv
// Analysis side: sample memory, scans, window sum, divider and result register.
module pbwf_back #(
  parameter int MAX_SAMPLES = pbwf_pkg::DEF_MAX_SAMPLES,
  parameter int SAMPLE_BITS = pbwf_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         wr_en,
  input  logic [$clog2(MAX_SAMPLES):0]                 wr_addr,
  input  logic [SAMPLE_BITS-1:0]                       wr_data,
  input  logic                                         q_empty,
  input  pbwf_pkg::job_t                               q_job,
  output logic                                         q_pop,
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  output logic [((38+2*SAMPLE_BITS+7)/8)*8-1:0]        out_tdata
);
  import pbwf_pkg::*;

  localparam int AW     = $clog2(MAX_SAMPLES);
  localparam int CW     = $clog2(MAX_SAMPLES + 1);
  localparam int XW     = CW + 4;
  localparam int SUMW   = SAMPLE_BITS + CW;
  localparam int DCW    = $clog2(SUMW + 1);
  localparam int OUT_TW = ((38 + 2*SAMPLE_BITS + 7) / 8) * 8;
  localparam int DEPTH  = 2 << AW;

  logic [SAMPLE_BITS-1:0] mem [DEPTH];

  back_st_t                      st_r, st_nxt;
  logic [CW-1:0]                 n_r, n_nxt;
  logic signed [SAMPLE_BITS-1:0] peak_r, peak_nxt;
  logic                          bank_r, bank_nxt;
  logic                          drop_r, drop_nxt;
  logic [CW-1:0]                 ra_r, ra_nxt;
  logic                          rv_r, rv_nxt;
  logic [CW-1:0]                 ri_r, ri_nxt;
  logic signed [SAMPLE_BITS-1:0] rd_r;
  logic signed [SAMPLE_BITS-1:0] w0_r, w1_r;
  logic [CW-1:0]                 first_r, first_nxt;
  logic [CW-1:0]                 last_r, last_nxt;
  logic [CW-1:0]                 len_r, len_nxt;
  logic signed [SUMW-1:0]        sum_r, sum_nxt;
  logic [CW-1:0]                 rem_r, rem_nxt;
  logic [SUMW-1:0]               quo_r, quo_nxt;
  logic                          neg_r, neg_nxt;
  logic [DCW-1:0]                cnt_r, cnt_nxt;
  logic                          out_vld_r, out_vld_nxt;
  logic [OUT_TW-1:0]             out_tdata_r, out_tdata_nxt;

  logic                          issue;
  logic                          qual;
  logic signed [SAMPLE_BITS+4:0] c10, p9;
  logic [XW-1:0]                 center, bound;
  logic [CW:0]                   rem_sh;
  logic [SUMW-1:0]               quo_sgn;
  logic [SAMPLE_BITS-1:0]        mean;

  assign c10    = (SAMPLE_BITS+5)'(w1_r) * (SAMPLE_BITS+5)'(signed'(5'sd10));
  assign p9     = (SAMPLE_BITS+5)'(peak_r) * (SAMPLE_BITS+5)'(signed'(5'sd9));
  assign qual   = (w1_r > w0_r) && (w1_r > rd_r) && (c10 >= p9);
  assign center = XW'(ri_r) + XW'(1);
  assign bound  = XW'(first_r) + XW'(MIN_GAP);
  assign rem_sh = {rem_r, quo_r[SUMW-1]};
  assign quo_sgn = neg_r ? (~quo_r + SUMW'(1)) : quo_r;
  assign mean   = quo_sgn[SAMPLE_BITS-1:0];

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_tdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_r <= mem[{bank_r, ra_r[AW-1:0]}];
    end
  end

  always_comb begin
    st_nxt        = st_r;
    n_nxt         = n_r;
    peak_nxt      = peak_r;
    bank_nxt      = bank_r;
    drop_nxt      = drop_r;
    ra_nxt        = ra_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    len_nxt       = len_r;
    sum_nxt       = sum_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_tdata_nxt = out_tdata_r;
    issue         = 1'b0;
    q_pop         = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          n_nxt    = CW'(q_job.count);
          peak_nxt = SAMPLE_BITS'(q_job.peak);
          bank_nxt = q_job.bank;
          drop_nxt = q_job.dropped;
          ra_nxt   = '0;
          if (CW'(q_job.count) < CW'(3)) begin
            first_nxt = '0;
            last_nxt  = CW'(q_job.count) - CW'(1);
            sum_nxt   = '0;
            st_nxt    = ST_SUM;
          end else begin
            st_nxt = ST_FWD;
          end
        end
      end
      ST_FWD: begin
        if (rv_r && ri_r >= CW'(2) && qual) begin
          first_nxt = ri_r - CW'(1);
          ra_nxt    = n_r - CW'(1);
          st_nxt    = ST_BWD;
        end else if (rv_r && ri_r == n_r - CW'(1)) begin
          first_nxt = '0;
          ra_nxt    = n_r - CW'(1);
          st_nxt    = ST_BWD;
        end else begin
          issue  = 1'b1;
          ra_nxt = ra_r + CW'(1);
        end
      end
      ST_BWD: begin
        if (rv_r && XW'(ri_r) + XW'(3) <= XW'(n_r) && center <= bound) begin
          last_nxt = n_r - CW'(1);
          ra_nxt   = first_r;
          sum_nxt  = '0;
          st_nxt   = ST_SUM;
        end else if (rv_r && XW'(ri_r) + XW'(3) <= XW'(n_r) && qual) begin
          last_nxt = ri_r + CW'(1);
          ra_nxt   = first_r;
          sum_nxt  = '0;
          st_nxt   = ST_SUM;
        end else begin
          issue  = 1'b1;
          ra_nxt = ra_r - CW'(1);
        end
      end
      ST_SUM: begin
        if (ra_r <= last_r) begin
          issue  = 1'b1;
          ra_nxt = ra_r + CW'(1);
        end
        if (rv_r) begin
          sum_nxt = sum_r + SUMW'(rd_r);
          if (ri_r == last_r) begin
            st_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        neg_nxt = sum_r < 0;
        quo_nxt = (sum_r < 0) ? SUMW'(-sum_r) : SUMW'(sum_r);
        rem_nxt = '0;
        cnt_nxt = DCW'(SUMW);
        len_nxt = last_r - first_r + CW'(1);
        st_nxt  = ST_DIV;
      end
      ST_DIV: begin
        if (rem_sh >= {1'b0, len_r}) begin
          rem_nxt = CW'(rem_sh - {1'b0, len_r});
          quo_nxt = {quo_r[SUMW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[CW-1:0];
          quo_nxt = {quo_r[SUMW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - DCW'(1);
        if (cnt_r == DCW'(1)) begin
          st_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_vld_r) begin
          out_vld_nxt   = 1'b1;
          out_tdata_nxt = OUT_TW'({drop_r, mean, peak_r, LEN_W'(len_r),
                                   END_W'(last_r), START_W'(first_r)});
          q_pop         = 1'b1;
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
    rv_nxt = issue;
    ri_nxt = issue ? ra_r : ri_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      rv_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      rv_r      <= rv_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    peak_r      <= peak_nxt;
    bank_r      <= bank_nxt;
    drop_r      <= drop_nxt;
    ra_r        <= ra_nxt;
    ri_r        <= ri_nxt;
    first_r     <= first_nxt;
    last_r      <= last_nxt;
    len_r       <= len_nxt;
    sum_r       <= sum_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    neg_r       <= neg_nxt;
    cnt_r       <= cnt_nxt;
    out_tdata_r <= out_tdata_nxt;
    if (rv_r) begin
      w0_r <= w1_r;
      w1_r <= rd_r;
    end
  end

endmodule
